>>> src/stg_pkg.sv
// Shared constants, types, tables and table builders of the sine tone generator.
package stg_pkg;

	// Field and storage sizes
	localparam int SINE_DEPTH = 1024;
	localparam int SAMPLE_W   = 16;
	localparam int DUR_W      = 24;
	localparam int PHASE_W    = 32;
	localparam int VOL_W      = 16;
	localparam int GAIN_FRAC  = 16;
	localparam int GAIN_W     = GAIN_FRAC + 1;
	localparam int PROD_W     = PHASE_W + GAIN_W;

	// Sine table: quarter wave, entries 0..QDEPTH inclusive
	localparam int IDX_W  = $clog2(SINE_DEPTH);
	localparam int QDEPTH = SINE_DEPTH / 4;
	localparam int QIDX_W = IDX_W - 1;
	localparam int MAG_W  = SAMPLE_W - 1;

	localparam logic [GAIN_W-1:0]  GAIN_ONE   = {1'b1, {GAIN_FRAC{1'b0}}};
	localparam logic [PHASE_W-1:0] HALF_CYCLE = {1'b1, {(PHASE_W-1){1'b0}}};

	// Configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_A4_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 2'd3;

	localparam logic [PHASE_W-1:0] A4_STEP_RST = 32'd39370534;
	localparam logic [DUR_W-1:0]   ATTACK_RST  = 24'd480;
	localparam logic [DUR_W-1:0]   RELEASE_RST = 24'd480;
	localparam logic [VOL_W-1:0]   BASE_RST    = 16'hFFFF;

	// Note decode: u = semis + acc + 12 * octave + 15, u / 12 by reciprocal
	localparam logic [2:0]  LETTER_NONE     = 3'd7;
	localparam logic [7:0]  OFFSET_BIAS     = 8'd15;
	localparam logic [7:0]  SEMIS_PER_OCT   = 8'd12;
	localparam logic [15:0] DIV12_MUL       = 16'd171;
	localparam int          DIV12_SHIFT     = 11;
	localparam logic [4:0]  STEP_SHIFT_BASE = 5'd22;

	// Request type codes
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	// Shared multiplier operand selection
	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_STEP,
		MUL_VOL,
		MUL_MAG,
		MUL_ATT,
		MUL_REL
	} mul_sel_t;

	// Controller to datapath
	typedef struct packed {
		logic     in_ready;
		mul_sel_t mul_sel;
		logic     gain_init;
		logic     div_start;
		logic     div_rel;
		logic     att_load;
		logic     rel_load;
		logic     note_load;
		logic     out_load;
	} stg_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic req_valid;
		logic tick;
		logic letter_ok;
		logic active;
		logic att_ramp;
		logic rel_ramp;
		logic div_done;
		logic out_free;
	} stg_sts_t;

	typedef logic [MAG_W-1:0] qsine_rom_t [QDEPTH+1];

	// Semitones above C for each letter
	function automatic logic [3:0] semis_of(input logic [2:0] letter);
		logic [3:0] s;
		unique case (letter)
			3'd0:    s = 4'd0;
			3'd1:    s = 4'd2;
			3'd2:    s = 4'd4;
			3'd3:    s = 4'd5;
			3'd4:    s = 4'd7;
			3'd5:    s = 4'd9;
			3'd6:    s = 4'd11;
			default: s = 4'd0;
		endcase
		return s;
	endfunction

	// 2^(k/12) in Q1.16
	function automatic logic [GAIN_W-1:0] pow_q16(input logic [3:0] k);
		logic [GAIN_W-1:0] p;
		unique case (k)
			4'd0:    p = 17'd65536;
			4'd1:    p = 17'd69433;
			4'd2:    p = 17'd73562;
			4'd3:    p = 17'd77936;
			4'd4:    p = 17'd82570;
			4'd5:    p = 17'd87480;
			4'd6:    p = 17'd92682;
			4'd7:    p = 17'd98193;
			4'd8:    p = 17'd104032;
			4'd9:    p = 17'd110218;
			4'd10:   p = 17'd116772;
			4'd11:   p = 17'd123715;
			default: p = 17'd65536;
		endcase
		return p;
	endfunction

	// Quarter-wave magnitudes from the odd Taylor series of sin(pi/2 * z), Q2.30
	function automatic qsine_rom_t build_qsine();
		qsine_rom_t  rom;
		logic [63:0] z;
		logic [63:0] z2;
		logic [63:0] p;
		logic [63:0] y;
		logic [63:0] mag;
		logic [63:0] amp;
		amp = (64'd1 << (SAMPLE_W - 1)) - 64'd1;
		for (int m = 0; m <= QDEPTH; m++) begin
			z   = (64'(m) << 30) / QDEPTH;
			z2  = (z * z) >> 30;
			p   = 64'd172271;
			p   = 64'd5026995 - ((p * z2) >> 30);
			p   = 64'd85569306 - ((p * z2) >> 30);
			p   = 64'd693598669 - ((p * z2) >> 30);
			p   = 64'd1686629713 - ((p * z2) >> 30);
			y   = (p * z) >> 30;
			mag = (y * amp + (64'd1 << 29)) >> 30;
			if (mag > amp) begin
				mag = amp;
			end
			rom[m] = mag[MAG_W-1:0];
		end
		return rom;
	endfunction

endpackage

>>> src/stg_if.sv
// Request and sample channel interfaces of the sine tone generator.
interface stg_req_if import stg_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    req_type;
	logic [2:0]              note_letter;
	logic signed [3:0]       accidental;
	logic [3:0]              octave;
	logic [DUR_W-1:0]        duration_samples;
	logic [VOL_W-1:0]        volume;

	modport source (
		output valid, req_type, note_letter, accidental, octave, duration_samples, volume,
		input  ready
	);
	modport sink (
		input  valid, req_type, note_letter, accidental, octave, duration_samples, volume,
		output ready
	);
endinterface

interface stg_smp_if import stg_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last_sample;

	modport source (
		output valid, sample, last_sample,
		input  ready
	);
	modport sink (
		input  valid, sample, last_sample,
		output ready
	);
endinterface

>>> src/stg_div.sv
// Restoring divider for ramp gains: floor(num * 2^16 / den), num < den, one bit a cycle.
module stg_div import stg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DUR_W-1:0]     num,
	input  logic [DUR_W-1:0]     den,
	output logic                 done,
	output logic [GAIN_FRAC-1:0] quo
);

	localparam int CNT_W = $clog2(GAIN_FRAC);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DUR_W-1:0]     rem_q;
	logic [DUR_W-1:0]     den_q;
	logic [GAIN_FRAC-1:0] quo_q;
	logic [DUR_W:0]       shl;
	logic [DUR_W:0]       diff;
	logic                 fits;

	// Trial subtract of the shifted remainder
	assign shl  = {rem_q, 1'b0};
	assign diff = shl - {1'b0, den_q};
	assign fits = ~diff[DUR_W];

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(GAIN_FRAC - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DUR_W-1:0] : shl[DUR_W-1:0];
			quo_q <= {quo_q[GAIN_FRAC-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

	// Remainder stays below the divisor through the whole run
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q < den_q))
		else $error("divider remainder reached divisor");

endmodule

>>> src/stg_dp.sv
// Datapath: config registers, note state, sine table, shared multiplier, divider, output register.
module stg_dp import stg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	stg_req_if.sink              req,
	stg_smp_if.source            smp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  stg_cmd_t             cmd,
	output stg_sts_t             sts
);

	localparam qsine_rom_t QSINE = build_qsine();

	// Config registers
	logic [PHASE_W-1:0] a4_step_q;
	logic [DUR_W-1:0]   attack_q;
	logic [DUR_W-1:0]   release_q;
	logic [VOL_W-1:0]   base_q;

	// Captured request
	logic               req_type_q;
	logic [2:0]         letter_q;
	logic [3:0]         acc_q;
	logic [3:0]         oct_q;
	logic [DUR_W-1:0]   dur_q;
	logic [VOL_W-1:0]   vol_q;

	// Note decode
	logic [7:0]         semi_u;
	logic [15:0]        semi_prod;
	logic [4:0]         oct_div;
	logic [7:0]         semi_rem;
	logic [3:0]         k_q;
	logic [4:0]         shr_q;

	// Note state
	logic               active_q;
	logic [DUR_W-1:0]   idx_q;
	logic [DUR_W-1:0]   len_q;
	logic [PHASE_W-1:0] phase_q;
	logic [PHASE_W-1:0] step_q;
	logic [VOL_W-1:0]   gain_q;

	// Sine lookup
	logic [1:0]         quad;
	logic [IDX_W-3:0]   qpos;
	logic [QIDX_W-1:0]  qidx;
	logic [MAG_W-1:0]   rom_mag_q;
	logic               neg_q;

	// Multiplier and gains
	logic [PHASE_W-1:0] mul_a;
	logic [GAIN_W-1:0]  mul_b;
	logic [PROD_W-1:0]  prod_q;
	logic [PROD_W-1:0]  step_shr;
	logic [PHASE_W-1:0] step_sat;
	logic [GAIN_W-1:0]  att_gain_q;
	logic [GAIN_W-1:0]  rel_gain_q;
	logic [MAG_W-1:0]   mag;

	// Ramp positions and divider
	logic [DUR_W-1:0]   rev;
	logic               last;
	logic               div_done;
	logic [GAIN_FRAC-1:0] div_quo;

	// Output register
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       last_q;
	logic                       out_free;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a4_step_q <= A4_STEP_RST;
			attack_q  <= ATTACK_RST;
			release_q <= RELEASE_RST;
			base_q    <= BASE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_A4_STEP: a4_step_q <= cfg_wdata[PHASE_W-1:0];
				CFG_ATTACK:  attack_q  <= cfg_wdata[DUR_W-1:0];
				CFG_RELEASE: release_q <= cfg_wdata[DUR_W-1:0];
				CFG_BASE:    base_q    <= cfg_wdata[VOL_W-1:0];
			endcase
		end
	end

	// Request capture on transfer
	assign req.ready = cmd.in_ready;

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_q <= req.req_type;
			letter_q   <= req.note_letter;
			acc_q      <= req.accidental;
			oct_q      <= req.octave;
			dur_q      <= req.duration_samples;
			vol_q      <= req.volume;
		end
	end

	// Semitone offset (biased positive) split into octave and step-in-octave
	always_comb begin
		semi_u    = 8'(semis_of(letter_q)) + {{4{acc_q[3]}}, acc_q}
			+ 8'(oct_q) * SEMIS_PER_OCT + OFFSET_BIAS;
		semi_prod = 16'(semi_u) * DIV12_MUL;
		oct_div   = semi_prod[DIV12_SHIFT+4:DIV12_SHIFT];
		semi_rem  = semi_u - 8'(oct_div) * SEMIS_PER_OCT;
	end

	always_ff @(posedge clk) begin
		k_q   <= semi_rem[3:0];
		shr_q <= STEP_SHIFT_BASE - oct_div;
	end

	// Phase step: shift and saturate at half a cycle
	always_comb begin
		step_shr = prod_q >> shr_q;
		step_sat = (step_shr > PROD_W'(HALF_CYCLE)) ? HALF_CYCLE : step_shr[PHASE_W-1:0];
	end

	// Sine table read, quarter-wave folded, registered output
	always_comb begin
		quad = phase_q[PHASE_W-1 -: 2];
		qpos = phase_q[PHASE_W-3 -: (IDX_W-2)];
		qidx = quad[0] ? (QIDX_W'(QDEPTH) - {1'b0, qpos}) : {1'b0, qpos};
	end

	always_ff @(posedge clk) begin
		rom_mag_q <= QSINE[qidx];
		neg_q     <= quad[1];
	end

	// Shared multiplier operand mux
	always_comb begin
		unique case (cmd.mul_sel)
			MUL_STEP: begin
				mul_a = a4_step_q;
				mul_b = pow_q16(k_q);
			end
			MUL_VOL: begin
				mul_a = PHASE_W'(base_q);
				mul_b = GAIN_W'(gain_q);
			end
			MUL_MAG: begin
				mul_a = PHASE_W'(rom_mag_q);
				mul_b = GAIN_W'(prod_q[GAIN_FRAC+VOL_W-1:GAIN_FRAC]);
			end
			MUL_ATT: begin
				mul_a = PHASE_W'(mag);
				mul_b = att_gain_q;
			end
			MUL_REL: begin
				mul_a = PHASE_W'(mag);
				mul_b = rel_gain_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mag = prod_q[GAIN_FRAC+MAG_W-1:GAIN_FRAC];

	always_ff @(posedge clk) begin
		if (cmd.mul_sel != MUL_NONE) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
	end

	// Ramp positions
	assign rev  = len_q - DUR_W'(1) - idx_q;
	assign last = (idx_q + DUR_W'(1)) == len_q;

	stg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (cmd.div_rel ? rev : idx_q),
		.den    (cmd.div_rel ? release_q : attack_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Envelope gains: unity unless a ramp quotient is loaded
	always_ff @(posedge clk) begin
		if (cmd.gain_init) begin
			att_gain_q <= GAIN_ONE;
			rel_gain_q <= GAIN_ONE;
		end else begin
			if (cmd.att_load) begin
				att_gain_q <= {1'b0, div_quo};
			end
			if (cmd.rel_load) begin
				rel_gain_q <= {1'b0, div_quo};
			end
		end
	end

	// Note state: loaded by a start, advanced by each sample loaded into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
			len_q    <= '0;
			phase_q  <= '0;
			step_q   <= '0;
			gain_q   <= '0;
		end else if (cmd.note_load) begin
			active_q <= (dur_q != '0);
			idx_q    <= '0;
			len_q    <= dur_q;
			phase_q  <= '0;
			step_q   <= step_sat;
			gain_q   <= vol_q;
		end else if (cmd.out_load) begin
			idx_q   <= idx_q + DUR_W'(1);
			phase_q <= phase_q + step_q;
			if (last) begin
				active_q <= 1'b0;
			end
		end
	end

	// Output register
	assign out_free = !out_valid_q || smp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (smp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sample_q <= neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
			last_q   <= last;
		end
	end

	assign smp.valid       = out_valid_q;
	assign smp.sample      = sample_q;
	assign smp.last_sample = last_q;

	// Status to the controller
	always_comb begin
		sts.req_valid = req.valid;
		sts.tick      = (req_type_q == REQ_TICK);
		sts.letter_ok = (letter_q != LETTER_NONE);
		sts.active    = active_q;
		sts.att_ramp  = (attack_q != '0) && (idx_q < attack_q);
		sts.rel_ramp  = (release_q != '0) && (rev < release_q);
		sts.div_done  = div_done;
		sts.out_free  = out_free;
	end

	// A running note never reaches its own length
	a_idx_in_note: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (idx_q < len_q))
		else $error("sample index ran past note length");

	// Step is saturated at half a cycle
	a_step_sat: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= HALF_CYCLE)
		else $error("phase step above half cycle");

endmodule

>>> src/stg_ctrl.sv
// Controller: sequences note decode, ramp divisions and the multiply chain per sample.
module stg_ctrl import stg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  stg_sts_t sts,
	output stg_cmd_t cmd
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DECODE   = 4'd1;
	localparam logic [3:0] S_STEP_MUL = 4'd2;
	localparam logic [3:0] S_STEP_SET = 4'd3;
	localparam logic [3:0] S_ATT_DIV  = 4'd4;
	localparam logic [3:0] S_REL_DIV  = 4'd5;
	localparam logic [3:0] S_MUL_VOL  = 4'd6;
	localparam logic [3:0] S_MUL_MAG  = 4'd7;
	localparam logic [3:0] S_MUL_ATT  = 4'd8;
	localparam logic [3:0] S_MUL_REL  = 4'd9;
	localparam logic [3:0] S_OUT      = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	// Next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.req_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (!sts.tick) begin
					state_d = sts.letter_ok ? S_STEP_MUL : S_IDLE;
				end else if (!sts.active) begin
					state_d = S_IDLE;
				end else begin
					cmd.gain_init = 1'b1;
					if (sts.att_ramp) begin
						cmd.div_start = 1'b1;
						state_d       = S_ATT_DIV;
					end else if (sts.rel_ramp) begin
						cmd.div_start = 1'b1;
						cmd.div_rel   = 1'b1;
						state_d       = S_REL_DIV;
					end else begin
						state_d = S_MUL_VOL;
					end
				end
			end
			S_STEP_MUL: begin
				cmd.mul_sel = MUL_STEP;
				state_d     = S_STEP_SET;
			end
			S_STEP_SET: begin
				cmd.note_load = 1'b1;
				state_d       = S_IDLE;
			end
			S_ATT_DIV: begin
				if (sts.div_done) begin
					cmd.att_load = 1'b1;
					if (sts.rel_ramp) begin
						cmd.div_start = 1'b1;
						cmd.div_rel   = 1'b1;
						state_d       = S_REL_DIV;
					end else begin
						state_d = S_MUL_VOL;
					end
				end
			end
			S_REL_DIV: begin
				if (sts.div_done) begin
					cmd.rel_load = 1'b1;
					state_d      = S_MUL_VOL;
				end
			end
			S_MUL_VOL: begin
				cmd.mul_sel = MUL_VOL;
				state_d     = S_MUL_MAG;
			end
			S_MUL_MAG: begin
				cmd.mul_sel = MUL_MAG;
				state_d     = S_MUL_ATT;
			end
			S_MUL_ATT: begin
				cmd.mul_sel = MUL_ATT;
				state_d     = S_MUL_REL;
			end
			S_MUL_REL: begin
				cmd.mul_sel = MUL_REL;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Every transfer is followed by a decode cycle
	a_transfer_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(sts.req_valid && cmd.in_ready) |=> (state_q == S_DECODE))
		else $error("transfer not followed by decode");

	// Divider is never restarted while a release division is pending
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REL_DIV) |-> !cmd.div_start)
		else $error("divider restarted during release division");

endmodule

>>> src/sine_tone_generator_with_ar_envelope.sv
// Top level of the sine tone generator with linear attack/release envelope.
// One item at a time. A start transfer (note letter, accidental, octave, length,
// volume) goes through decode, one pass through the shared 32x17 multiplier
// that scales the A4 step by 2^(k/12), then shift and load of the note. A tick
// transfer of an active note goes through decode, a division for each of the
// attack and release gains that applies, and the multiply chain, then waits for a
// free output register. Each gain comes from a restoring divider that yields one
// quotient bit per cycle. Starts with the invalid letter code and ticks with no
// active note give no result. Results wait in an output register, so a new item
// is taken while the last sample is still held.
module sine_tone_generator_with_ar_envelope import stg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	stg_req_if.sink              req,
	stg_smp_if.source            smp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	stg_cmd_t cmd;
	stg_sts_t sts;

	// Sequencer
	stg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Datapath
	stg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.smp       (smp),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
